// ===== hw/rtl/gjs_pkg.sv =====
// Shared types, constants and helpers for the Gauss-Jordan solver.
// Used by the controller, the datapath and the top level; depends on nothing.
package gjs_pkg;

  localparam int DATA_W = 32;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 5;
  localparam int CNT_W  = 5;

  // Commands from the controller to the datapath for one cycle.
  typedef struct packed {
    logic             wr_en;
    logic             wr_load;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             cap_piv;
    logic             cap_mult;
    logic             cap_aik;
    logic             cap_ajk;
    logic             cap_prod;
    logic             div_start;
    logic             sel_sol;
    logic             emit;
    logic             emit_err;
    logic             res_last;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic rd_zero;
    logic div_busy;
  } sts_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [64:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 65'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -65'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/gauss_jordan_solver.sv =====
// Top level of the Gauss-Jordan linear system solver (no pivoting, Q16.16).
// Depends on gjs_pkg, gjs_ctrl, gjs_datapath (and through it gjs_ram, gjs_div).
//
// Usage: coefficients of the augmented n by n+1 system are loaded one per
// cycle; a transaction is accepted on each rising edge where start_i is high
// and busy_o is low. Column n is the right-hand side; entries outside the
// current system size are dropped. The transaction with load_last_i set is
// stored like the others and then starts the solve, during which busy_o stays
// high. The solve walks the matrix memory: each element update takes a read
// of the pivot-row entry, a read of the target entry, one multiply and a
// divide on the shared bit-serial divider. A solve of size n does
// n * (n - 1) * (n + 1) such updates, plus one divide per unknown to
// form the results. Results then appear one at a time,
// each on the result ports for exactly one cycle with result_valid_o high;
// the receiver cannot stall them and must take every one. A zero pivot gives
// a single result with solve_status_o set and result_last_o set; otherwise
// the n unknowns come out in order, the final one flagged by result_last_o.
// The reduced matrix stays in memory after a solve. The size register n_size
// sits at APB address 0 (reset value 2) and should be written only while the
// block is idle. Memory contents are undefined until written; no clearing
// pass runs after reset.
module gauss_jordan_solver #(
  parameter int MAX_N = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // load channel
  input  logic               start_i,
  output logic               busy_o,
  input  logic [3:0]         row_index_i,
  input  logic [4:0]         column_index_i,
  input  logic signed [31:0] coefficient_i,
  input  logic               load_last_i,
  // result channel
  output logic               result_valid_o,
  output logic [3:0]         unknown_index_o,
  output logic signed [31:0] solution_value_o,
  output logic               solve_status_o,
  output logic               result_last_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import gjs_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [4:0] n_size_q;
  logic       reg_sel;

  // Only one register exists, so the word index is the upper address bit.
  assign reg_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {27'd0, n_size_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_size_q <= 5'd2;
    end else if (psel && penable && pwrite && reg_sel) begin
      n_size_q <= pwdata[4:0];
    end
  end

  // The controller sequences the loads and the elimination; the datapath
  // holds the matrix memory and does all the arithmetic.
  gjs_ctrl #(
    .MAX_N (MAX_N)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .row_index_i    (row_index_i),
    .column_index_i (column_index_i),
    .load_last_i    (load_last_i),
    .n_size_i       (n_size_q),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (busy_o)
  );

  gjs_datapath #(
    .MAX_N (MAX_N)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .coefficient_i    (coefficient_i),
    .result_valid_o   (result_valid_o),
    .unknown_index_o  (unknown_index_o),
    .solution_value_o (solution_value_o),
    .solve_status_o   (solve_status_o),
    .result_last_o    (result_last_o)
  );

endmodule

// ===== hw/rtl/gjs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; no package needed.
module gjs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 272
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/gjs_div.sv =====
// Radix-2 restoring divider, signed 64 by 32 bits, quotient truncated toward zero.
// One quotient bit per cycle; stands alone.
module gjs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] dividend_i,
  input  logic signed [31:0] divisor_i,
  output logic               busy_o,
  output logic signed [63:0] quotient_o
);

  localparam int Steps = 64;
  localparam int CntW  = $clog2(Steps + 1);

  logic [31:0]     rem_q, rem_d;
  logic [63:0]     quo_q, quo_d;
  logic [31:0]     dvs_q, dvs_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [32:0]     rem_sh;
  logic [33:0]     diff;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_sh = {rem_q, quo_q[63]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i[63] ? 64'(-dividend_i) : dividend_i;
      dvs_d  = divisor_i[31] ? 32'(-divisor_i) : divisor_i;
      neg_d  = dividend_i[63] ^ divisor_i[31];
      cnt_d  = CntW'(Steps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[33]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = neg_q ? 64'(-quo_q) : quo_q;

endmodule

// ===== hw/rtl/gjs_datapath.sv =====
// Datapath of the solver: matrix memory, operand registers, multiplier,
// shared divider and result registers. Depends on gjs_pkg, gjs_ram, gjs_div.
module gjs_datapath #(
  parameter int MAX_N = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gjs_pkg::cmd_t        cmd_i,
  output gjs_pkg::sts_t        sts_o,
  input  logic signed [31:0]   coefficient_i,
  output logic                 result_valid_o,
  output logic [3:0]           unknown_index_o,
  output logic signed [31:0]   solution_value_o,
  output logic                 solve_status_o,
  output logic                 result_last_o
);
  import gjs_pkg::*;

  localparam int Cols  = MAX_N + 1;
  localparam int Depth = MAX_N * Cols;
  localparam int AW    = $clog2(Depth);

  logic [AW-1:0]             addr;
  logic [DATA_W-1:0]         rd_data;
  logic [DATA_W-1:0]         wr_data;
  logic signed [DATA_W-1:0]  piv_q, mult_q, aik_q, ajk_q;
  logic signed [63:0]        prod_q;
  logic signed [63:0]        dividend;
  logic signed [63:0]        quotient;
  logic                      div_busy;
  logic signed [64:0]        elim_diff;
  logic                      res_valid_q;
  logic [ROW_W-1:0]          res_idx_q;
  logic signed [DATA_W-1:0]  res_val_q;
  logic                      res_sts_q;
  logic                      res_last_q;

  assign addr = AW'(AW'(cmd_i.row) * AW'(Cols)) + AW'(cmd_i.col);

  assign elim_diff = {{33{ajk_q[31]}}, ajk_q} - {quotient[63], quotient};
  assign wr_data   = cmd_i.wr_load ? coefficient_i : sat32(elim_diff);
  assign dividend  = cmd_i.sel_sol ? {{16{aik_q[31]}}, aik_q, 16'h0000} : prod_q;

  gjs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (addr),
    .wdata_i (wr_data),
    .raddr_i (addr),
    .rdata_o (rd_data)
  );

  gjs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (piv_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_piv) begin
      piv_q <= rd_data;
    end
    if (cmd_i.cap_mult) begin
      mult_q <= rd_data;
    end
    if (cmd_i.cap_aik) begin
      aik_q <= rd_data;
    end
    if (cmd_i.cap_ajk) begin
      ajk_q <= rd_data;
    end
    if (cmd_i.cap_prod) begin
      prod_q <= aik_q * mult_q;
    end
    if (cmd_i.emit) begin
      res_idx_q  <= cmd_i.row;
      res_val_q  <= cmd_i.emit_err ? '0 : sat32({quotient[63], quotient});
      res_sts_q  <= cmd_i.emit_err;
      res_last_q <= cmd_i.emit_err | cmd_i.res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
    end
  end

  assign sts_o.rd_zero  = (rd_data == '0);
  assign sts_o.div_busy = div_busy;

  assign result_valid_o   = res_valid_q;
  assign unknown_index_o  = res_idx_q;
  assign solution_value_o = res_val_q;
  assign solve_status_o   = res_sts_q;
  assign result_last_o    = res_last_q;

endmodule

// ===== hw/rtl/gjs_ctrl.sv =====
// Controller of the solver: load handshake and the sequencer that walks
// pivots, rows and columns. Depends on gjs_pkg.
module gjs_ctrl #(
  parameter int MAX_N = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [3:0]                row_index_i,
  input  logic [4:0]                column_index_i,
  input  logic                      load_last_i,
  input  logic [4:0]                n_size_i,
  input  gjs_pkg::sts_t             sts_i,
  output gjs_pkg::cmd_t             cmd_o,
  output logic                      busy_o
);
  import gjs_pkg::*;

  localparam int NCap = (MAX_N < 16) ? MAX_N : 16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PIV_RD,
    S_PIV_CHK,
    S_MUL_RD,
    S_MUL_CAP,
    S_AIK_RD,
    S_AJK_RD,
    S_MULT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SOL_RD_D,
    S_SOL_RD_N,
    S_SOL_CAP,
    S_SOL_GO,
    S_SOL_WAIT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] j_first, j_inc, j_after;
  logic             in_range;
  logic             i_last;

  always_comb begin
    if (n_size_i == '0) begin
      n_eff = CNT_W'(1);
    end else if (n_size_i > CNT_W'(NCap)) begin
      n_eff = CNT_W'(NCap);
    end else begin
      n_eff = n_size_i;
    end
  end

  assign in_range = ({1'b0, row_index_i} < n_eff) && (column_index_i <= n_eff);
  assign j_first  = (i_q == '0) ? CNT_W'(1) : '0;
  assign j_inc    = j_q + CNT_W'(1);
  assign j_after  = (j_inc == i_q) ? j_q + CNT_W'(2) : j_inc;
  assign i_last   = (i_q + CNT_W'(1)) == n_eff;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.row     = row_index_i;
        cmd_o.col     = column_index_i;
        cmd_o.wr_load = 1'b1;
        if (start_i) begin
          cmd_o.wr_en = in_range;
          if (load_last_i) begin
            i_d     = '0;
            state_d = S_PIV_RD;
          end
        end
      end
      S_PIV_RD: begin
        cmd_o.row = ROW_W'(i_q);
        cmd_o.col = COL_W'(i_q);
        state_d   = S_PIV_CHK;
      end
      S_PIV_CHK: begin
        cmd_o.row = ROW_W'(i_q);
        if (sts_i.rd_zero) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_err = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.cap_piv = 1'b1;
          j_d           = j_first;
          if (j_first >= n_eff) begin
            if (i_last) begin
              i_d     = '0;
              state_d = S_SOL_RD_D;
            end else begin
              i_d     = i_q + CNT_W'(1);
              state_d = S_PIV_RD;
            end
          end else begin
            state_d = S_MUL_RD;
          end
        end
      end
      S_MUL_RD: begin
        cmd_o.row = ROW_W'(j_q);
        cmd_o.col = COL_W'(i_q);
        state_d   = S_MUL_CAP;
      end
      S_MUL_CAP: begin
        cmd_o.cap_mult = 1'b1;
        k_d            = '0;
        state_d        = S_AIK_RD;
      end
      S_AIK_RD: begin
        cmd_o.row = ROW_W'(i_q);
        cmd_o.col = COL_W'(k_q);
        state_d   = S_AJK_RD;
      end
      S_AJK_RD: begin
        cmd_o.cap_aik = 1'b1;
        cmd_o.row     = ROW_W'(j_q);
        cmd_o.col     = COL_W'(k_q);
        state_d       = S_MULT;
      end
      S_MULT: begin
        cmd_o.cap_ajk  = 1'b1;
        cmd_o.cap_prod = 1'b1;
        state_d        = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        cmd_o.row = ROW_W'(j_q);
        cmd_o.col = COL_W'(k_q);
        if (!sts_i.div_busy) begin
          cmd_o.wr_en = 1'b1;
          if (k_q == n_eff) begin
            if (j_after >= n_eff) begin
              if (i_last) begin
                i_d     = '0;
                state_d = S_SOL_RD_D;
              end else begin
                i_d     = i_q + CNT_W'(1);
                state_d = S_PIV_RD;
              end
            end else begin
              j_d     = j_after;
              state_d = S_MUL_RD;
            end
          end else begin
            k_d     = k_q + CNT_W'(1);
            state_d = S_AIK_RD;
          end
        end
      end
      S_SOL_RD_D: begin
        cmd_o.row = ROW_W'(i_q);
        cmd_o.col = COL_W'(i_q);
        state_d   = S_SOL_RD_N;
      end
      S_SOL_RD_N: begin
        cmd_o.cap_piv = 1'b1;
        cmd_o.row     = ROW_W'(i_q);
        cmd_o.col     = COL_W'(n_eff);
        state_d       = S_SOL_CAP;
      end
      S_SOL_CAP: begin
        cmd_o.cap_aik = 1'b1;
        state_d       = S_SOL_GO;
      end
      S_SOL_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.sel_sol   = 1'b1;
        state_d         = S_SOL_WAIT;
      end
      S_SOL_WAIT: begin
        cmd_o.row      = ROW_W'(i_q);
        cmd_o.res_last = i_last;
        if (!sts_i.div_busy) begin
          cmd_o.emit = 1'b1;
          if (i_last) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + CNT_W'(1);
            state_d = S_SOL_RD_D;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
